FILE: design/dcig_pkg.sv
// Shared types, command codes and bit positions for the dual CPU interrupt glue.
package dcig_pkg;

	typedef enum logic [3:0] {
		CMD_RD_MASK0  = 4'd0,
		CMD_RD_MASK1  = 4'd1,
		CMD_RD_SRC    = 4'd2,
		CMD_RD_XPROC  = 4'd3,
		CMD_WR_MASK0  = 4'd4,
		CMD_WR_MASK1  = 4'd5,
		CMD_WR_XPROC  = 4'd6,
		CMD_WR_RESETS = 4'd7,
		CMD_SET_SRC   = 4'd8
	} cmd_e;

	localparam int unsigned FLAG_POS    = 31;
	localparam int unsigned SMI0_POS    = 30;
	localparam int unsigned SMI1_POS    = 29;
	localparam int unsigned TLB0_POS    = 27;
	localparam int unsigned TLB1_POS    = 26;
	localparam int unsigned CPUID_POS   = 25;
	localparam int unsigned RST_EN_POS  = 29;
	localparam int unsigned RST_REL_POS = 31;

	typedef struct packed {
		logic [3:0]  command;
		logic [31:0] write_data;
		logic        cpu_id;
		logic [4:0]  irq_bit;
		logic        irq_level;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq_cpu0;
		logic        irq_cpu1;
		logic        smi_cpu0;
		logic        smi_cpu1;
		logic        tlbisync_cpu0;
		logic        tlbisync_cpu1;
		logic        cpu1_reset;
	} res_t;

	// apply a set/clear write: flag bit picks set or clear for the other bits
	function automatic logic [31:0] set_clear(input logic [31:0] cur, input logic [31:0] word);
		logic [31:0] sel;
		sel = word & ~(32'd1 << FLAG_POS);
		set_clear = word[FLAG_POS] ? (cur | sel) : (cur & ~sel);
	endfunction

endpackage

FILE: design/dcig_regs.sv
// Register file of the interrupt glue: state update and result word.
module dcig_regs (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           upd,
	input  dcig_pkg::req_t req,
	output dcig_pkg::res_t res
);

	logic [31:0] mask0_q, mask1_q, src_q, xproc_q;
	logic        rst1_q;
	logic [31:0] mask0_d, mask1_d, src_d, xproc_d;
	logic        rst1_d;
	logic [31:0] rd;
	dcig_pkg::cmd_e cmd;

	assign cmd = dcig_pkg::cmd_e'(req.command);

	always_comb begin
		mask0_d = mask0_q;
		mask1_d = mask1_q;
		src_d   = src_q;
		xproc_d = xproc_q;
		rst1_d  = rst1_q;
		rd      = 32'd0;
		case (cmd)
			dcig_pkg::CMD_RD_MASK0: begin
				rd = mask0_q;
			end
			dcig_pkg::CMD_RD_MASK1: begin
				rd = mask1_q;
			end
			dcig_pkg::CMD_RD_SRC: begin
				rd = src_q;
			end
			dcig_pkg::CMD_RD_XPROC: begin
				rd = xproc_q;
				rd[dcig_pkg::CPUID_POS] = req.cpu_id;
			end
			dcig_pkg::CMD_WR_MASK0: begin
				mask0_d = dcig_pkg::set_clear(mask0_q, req.write_data);
			end
			dcig_pkg::CMD_WR_MASK1: begin
				mask1_d = dcig_pkg::set_clear(mask1_q, req.write_data);
			end
			dcig_pkg::CMD_WR_XPROC: begin
				xproc_d = dcig_pkg::set_clear(xproc_q, req.write_data);
			end
			dcig_pkg::CMD_WR_RESETS: begin
				if (req.write_data[dcig_pkg::RST_EN_POS]) begin
					rst1_d = ~req.write_data[dcig_pkg::RST_REL_POS];
				end
			end
			dcig_pkg::CMD_SET_SRC: begin
				src_d[req.irq_bit] = req.irq_level;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask0_q <= 32'd0;
			mask1_q <= 32'd0;
			src_q   <= 32'd0;
			xproc_q <= 32'd0;
			rst1_q  <= 1'b1;
		end else if (upd) begin
			mask0_q <= mask0_d;
			mask1_q <= mask1_d;
			src_q   <= src_d;
			xproc_q <= xproc_d;
			rst1_q  <= rst1_d;
		end
	end

	always_comb begin
		res.read_data     = rd;
		res.irq_cpu0      = |(src_d & mask0_d);
		res.irq_cpu1      = |(src_d & mask1_d);
		res.smi_cpu0      = xproc_d[dcig_pkg::SMI0_POS];
		res.smi_cpu1      = xproc_d[dcig_pkg::SMI1_POS];
		res.tlbisync_cpu0 = ~xproc_d[dcig_pkg::TLB0_POS];
		res.tlbisync_cpu1 = ~xproc_d[dcig_pkg::TLB1_POS];
		res.cpu1_reset    = rst1_d;
	end

endmodule

FILE: design/dual_cpu_interrupt_glue_registers_unit.sv
// Top level of the dual CPU interrupt glue: input register, register file, result register.
//
//   channel | direction | handshake          | word
//   in      | into      | in_valid/in_stall   | command, write_data, cpu_id, irq_bit, irq_level
//   out     | out of    | out_valid/out_stall | read_data, irq/smi/tlbisync lines, cpu1_reset
//
// One word per cycle while out_stall is low; results come out of the result register.
// The input register feeds the register file, which updates state and forms the
// result in the same cycle as it loads the result register.
// Reset clears the valid flags and the state registers and sets the held CPU1 reset bit.
// A stalled result holds the input register; in_stall rises only when it is full.
module dual_cpu_interrupt_glue_registers_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  command,
	input  logic [31:0] write_data,
	input  logic        cpu_id,
	input  logic [4:0]  irq_bit,
	input  logic        irq_level,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_data,
	output logic        irq_cpu0,
	output logic        irq_cpu1,
	output logic        smi_cpu0,
	output logic        smi_cpu1,
	output logic        tlbisync_cpu0,
	output logic        tlbisync_cpu1,
	output logic        cpu1_reset
);

	logic           valid_s1;
	dcig_pkg::req_t req_s1;
	logic           valid_s2;
	dcig_pkg::res_t res_s2;
	dcig_pkg::res_t res;
	logic           adv;

	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1.command    <= command;
			req_s1.write_data <= write_data;
			req_s1.cpu_id     <= cpu_id;
			req_s1.irq_bit    <= irq_bit;
			req_s1.irq_level  <= irq_level;
		end
	end

	dcig_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (adv),
		.req    (req_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || !out_stall) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign read_data     = res_s2.read_data;
	assign irq_cpu0      = res_s2.irq_cpu0;
	assign irq_cpu1      = res_s2.irq_cpu1;
	assign smi_cpu0      = res_s2.smi_cpu0;
	assign smi_cpu1      = res_s2.smi_cpu1;
	assign tlbisync_cpu0 = res_s2.tlbisync_cpu0;
	assign tlbisync_cpu1 = res_s2.tlbisync_cpu1;
	assign cpu1_reset    = res_s2.cpu1_reset;

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled without a held word");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> (valid_s1 && $stable(req_s1)))
		else $error("held input word changed");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_stall && !valid_s1) |=> !valid_s2)
		else $error("result repeated after delivery");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("advanced word lost");

endmodule

FILE: tb/sv/dual_cpu_interrupt_glue_registers_unit_test.sv
// Self-checking testbench for the dual CPU interrupt glue: directed table, then random bus words.
`timescale 1ns / 1ps

module dual_cpu_interrupt_glue_registers_unit_test;

	localparam logic [3:0]  CMD_UNUSED_LO = 4'd9;
	localparam logic [3:0]  CMD_UNUSED_HI = 4'd15;
	localparam logic [31:0] FLAG_WORD     = 32'h1 << dcig_pkg::FLAG_POS;
	localparam logic [31:0] CPUID_WORD    = 32'h1 << dcig_pkg::CPUID_POS;
	localparam logic [31:0] ALL_ONES      = 32'hFFFF_FFFF;
	localparam logic [31:0] ALL_BUT_FLAG  = 32'h7FFF_FFFF;
	// irq0, irq1, smi0, smi1, tlbisync0, tlbisync1, cpu1_reset as they come out of reset
	localparam logic [6:0]  IDLE_LINES    = 7'b0000111;
	localparam int          RANDOM_WORDS  = 1250;
	localparam int          STALL_LIMIT   = 4000;
	localparam int          TAIL_CYCLES   = 8;

	typedef struct packed {
		dcig_pkg::req_t word;
		logic           pinned;
		dcig_pkg::res_t lines;
	} glue_row_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_stall;
	logic [3:0]  command    = '0;
	logic [31:0] write_data = '0;
	logic        cpu_id     = 1'b0;
	logic [4:0]  irq_bit    = '0;
	logic        irq_level  = 1'b0;
	logic        out_valid;
	logic        out_stall  = 1'b0;
	logic [31:0] read_data;
	logic        irq_cpu0;
	logic        irq_cpu1;
	logic        smi_cpu0;
	logic        smi_cpu1;
	logic        tlbisync_cpu0;
	logic        tlbisync_cpu1;
	logic        cpu1_reset;

	logic           pin_flag  = 1'b0;
	dcig_pkg::res_t pin_lines = '0;

	logic [31:0] cpu0_mask;
	logic [31:0] cpu1_mask;
	logic [31:0] source_reg;
	logic [31:0] xproc_reg;
	logic        cpu1_held_in_reset;

	dcig_pkg::res_t expected_lines [$];
	int             fail_count = 0;
	int             quiet_cycles = 0;
	int             burst_left = 0;

	glue_row_t directed_rows [0:24] = '{
		'{'{dcig_pkg::CMD_RD_MASK0,  32'h0,    1'b0, 5'd0,  1'b0}, 1'b1, {32'h0, IDLE_LINES}},
		'{'{dcig_pkg::CMD_RD_XPROC,  32'h0,    1'b1, 5'd0,  1'b0}, 1'b1,
			{CPUID_WORD, IDLE_LINES}},
		'{'{dcig_pkg::CMD_RD_SRC,    ALL_ONES, 1'b0, 5'd31, 1'b1}, 1'b1, {32'h0, IDLE_LINES}},
		'{'{CMD_UNUSED_LO,           ALL_ONES, 1'b1, 5'd31, 1'b1}, 1'b1, {32'h0, IDLE_LINES}},
		'{'{CMD_UNUSED_HI,           ALL_ONES, 1'b0, 5'd0,  1'b1}, 1'b1, {32'h0, IDLE_LINES}},
		'{'{dcig_pkg::CMD_WR_MASK0,  ALL_ONES, 1'b0, 5'd0,  1'b0}, 1'b1, {32'h0, IDLE_LINES}},
		'{'{dcig_pkg::CMD_WR_MASK1,  ALL_ONES, 1'b1, 5'd0,  1'b0}, 1'b1, {32'h0, IDLE_LINES}},
		'{'{dcig_pkg::CMD_RD_MASK0,  32'h0,    1'b0, 5'd0,  1'b0}, 1'b1,
			{ALL_BUT_FLAG, IDLE_LINES}},
		'{'{dcig_pkg::CMD_RD_MASK1,  32'h0,    1'b1, 5'd0,  1'b0}, 1'b1,
			{ALL_BUT_FLAG, IDLE_LINES}},
		'{'{dcig_pkg::CMD_SET_SRC,   32'h0,         1'b0, 5'd31, 1'b1}, 1'b0, '0},
		'{'{dcig_pkg::CMD_RD_SRC,    32'h0,         1'b1, 5'd0,  1'b0}, 1'b0, '0},
		'{'{dcig_pkg::CMD_SET_SRC,   32'h0,         1'b1, 5'd0,  1'b1}, 1'b0, '0},
		'{'{dcig_pkg::CMD_WR_MASK0,  32'h0000_0001, 1'b0, 5'd0,  1'b0}, 1'b0, '0},
		'{'{dcig_pkg::CMD_WR_XPROC,  ALL_ONES,      1'b0, 5'd0,  1'b0}, 1'b0, '0},
		'{'{dcig_pkg::CMD_RD_XPROC,  32'h0,         1'b0, 5'd0,  1'b0}, 1'b0, '0},
		'{'{dcig_pkg::CMD_RD_XPROC,  32'h0,         1'b1, 5'd0,  1'b0}, 1'b0, '0},
		'{'{dcig_pkg::CMD_WR_RESETS, 32'hA000_0000, 1'b0, 5'd0,  1'b0}, 1'b0, '0},
		'{'{dcig_pkg::CMD_WR_RESETS, 32'h8000_0000, 1'b1, 5'd0,  1'b0}, 1'b0, '0},
		'{'{dcig_pkg::CMD_WR_RESETS, 32'h2000_0000, 1'b0, 5'd0,  1'b0}, 1'b0, '0},
		'{'{dcig_pkg::CMD_WR_RESETS, ALL_ONES,      1'b1, 5'd0,  1'b0}, 1'b0, '0},
		'{'{dcig_pkg::CMD_WR_XPROC,  ALL_BUT_FLAG,  1'b0, 5'd0,  1'b0}, 1'b0, '0},
		'{'{dcig_pkg::CMD_SET_SRC,   ALL_ONES,      1'b0, 5'd0,  1'b0}, 1'b0, '0},
		'{'{dcig_pkg::CMD_SET_SRC,   32'h0,         1'b1, 5'd31, 1'b0}, 1'b0, '0},
		'{'{dcig_pkg::CMD_WR_MASK1,  ALL_BUT_FLAG,  1'b1, 5'd0,  1'b0}, 1'b0, '0},
		'{'{dcig_pkg::CMD_RD_MASK1,  32'h0,         1'b0, 5'd0,  1'b0}, 1'b0, '0}
	};

	dual_cpu_interrupt_glue_registers_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.write_data   (write_data),
		.cpu_id       (cpu_id),
		.irq_bit      (irq_bit),
		.irq_level    (irq_level),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.read_data    (read_data),
		.irq_cpu0     (irq_cpu0),
		.irq_cpu1     (irq_cpu1),
		.smi_cpu0     (smi_cpu0),
		.smi_cpu1     (smi_cpu1),
		.tlbisync_cpu0(tlbisync_cpu0),
		.tlbisync_cpu1(tlbisync_cpu1),
		.cpu1_reset   (cpu1_reset)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic [31:0] set_or_clear(input logic [31:0] held, input logic [31:0] word);
		logic [31:0] picked;
		picked = word & ~FLAG_WORD;
		return word[dcig_pkg::FLAG_POS] ? (held | picked) : (held & ~picked);
	endfunction

	function automatic dcig_pkg::res_t apply_glue_word(input dcig_pkg::req_t w);
		dcig_pkg::res_t r;
		r = '0;
		case (w.command)
			dcig_pkg::CMD_RD_MASK0: r.read_data = cpu0_mask;
			dcig_pkg::CMD_RD_MASK1: r.read_data = cpu1_mask;
			dcig_pkg::CMD_RD_SRC:   r.read_data = source_reg;
			dcig_pkg::CMD_RD_XPROC: begin
				r.read_data = xproc_reg;
				r.read_data[dcig_pkg::CPUID_POS] = w.cpu_id;
			end
			dcig_pkg::CMD_WR_MASK0: cpu0_mask = set_or_clear(cpu0_mask, w.write_data);
			dcig_pkg::CMD_WR_MASK1: cpu1_mask = set_or_clear(cpu1_mask, w.write_data);
			dcig_pkg::CMD_WR_XPROC: xproc_reg = set_or_clear(xproc_reg, w.write_data);
			dcig_pkg::CMD_WR_RESETS: begin
				if (w.write_data[dcig_pkg::RST_EN_POS])
					cpu1_held_in_reset = ~w.write_data[dcig_pkg::RST_REL_POS];
			end
			dcig_pkg::CMD_SET_SRC:  source_reg[w.irq_bit] = w.irq_level;
			default: ;
		endcase
		r.irq_cpu0      = |(source_reg & cpu0_mask);
		r.irq_cpu1      = |(source_reg & cpu1_mask);
		r.smi_cpu0      = xproc_reg[dcig_pkg::SMI0_POS];
		r.smi_cpu1      = xproc_reg[dcig_pkg::SMI1_POS];
		r.tlbisync_cpu0 = ~xproc_reg[dcig_pkg::TLB0_POS];
		r.tlbisync_cpu1 = ~xproc_reg[dcig_pkg::TLB1_POS];
		r.cpu1_reset    = cpu1_held_in_reset;
		return r;
	endfunction

	always @(posedge clk) begin
		dcig_pkg::res_t seen;
		dcig_pkg::res_t want;
		dcig_pkg::res_t next;
		if (!arst_n) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (out_valid && !out_stall) begin
				quiet_cycles = 0;
				seen = {read_data, irq_cpu0, irq_cpu1, smi_cpu0, smi_cpu1,
					tlbisync_cpu0, tlbisync_cpu1, cpu1_reset};
				if (expected_lines.size() == 0) begin
					$display("%0t: unexpected word: expected none, actual %h", $time, seen);
					fail_count++;
				end else begin
					want = expected_lines.pop_front();
					if (want !== seen) begin
						$display("%0t: result mismatch: expected %h, actual %h",
							$time, want, seen);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				quiet_cycles = 0;
				next = apply_glue_word({command, write_data, cpu_id, irq_bit, irq_level});
				expected_lines.push_back(pin_flag ? pin_lines : next);
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// receiver: stall in segments of differing character
	initial begin
		int mode;
		int span;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(4, 64);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= 1'($urandom_range(0, 1));
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
	endtask

	task automatic send_word(input dcig_pkg::req_t w, input logic pinned,
		input dcig_pkg::res_t lines);
		pace_sender();
		@(negedge clk);
		in_valid   <= 1'b1;
		command    <= w.command;
		write_data <= w.write_data;
		cpu_id     <= w.cpu_id;
		irq_bit    <= w.irq_bit;
		irq_level  <= w.irq_level;
		pin_flag   <= pinned;
		pin_lines  <= lines;
		do @(posedge clk); while (!(in_valid && !in_stall));
	endtask

	initial begin
		dcig_pkg::req_t w;
		int pick;
		cpu0_mask          = '0;
		cpu1_mask          = '0;
		source_reg         = '0;
		xproc_reg          = '0;
		cpu1_held_in_reset = 1'b1;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_word(directed_rows[i].word, directed_rows[i].pinned, directed_rows[i].lines);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n == RANDOM_WORDS / 2) begin
				@(negedge clk);
				in_valid <= 1'b0;
				while (expected_lines.size() != 0) @(posedge clk);
			end
			pick = $urandom_range(0, 99);
			if (pick < 6)
				w.command = 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
			else if (pick < 35)
				w.command = dcig_pkg::CMD_SET_SRC;
			else
				w.command = 4'($urandom_range(dcig_pkg::CMD_RD_MASK0,
					dcig_pkg::CMD_WR_RESETS));
			w.write_data = $urandom;
			// thin out the word so masks and cross-processor bits stay mixed
			if ($urandom_range(0, 1))
				w.write_data = w.write_data & ($urandom | FLAG_WORD) & ($urandom | FLAG_WORD);
			w.cpu_id    = 1'($urandom_range(0, 1));
			w.irq_bit   = 5'($urandom_range(0, 31));
			w.irq_level = 1'($urandom_range(0, 1));
			send_word(w, 1'b0, '0);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_lines.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
